// ===== rtl/vms_pkg.sv =====
// shared types and widths for the vector magnitude scaler
// no dependencies
package vms_pkg;

    localparam int CW = 24;
    localparam int TW = CW - 1;
    localparam int SW = 2 * CW;
    localparam int PW = CW + TW;
    localparam int LW = CW;
    localparam int POS_W = $clog2(CW);

    typedef enum logic {
        OP_SET   = 1'b0,
        OP_LIMIT = 1'b1
    } vms_op_t;

    typedef struct packed {
        logic                 operation;
        logic signed [CW-1:0] vec_x;
        logic signed [CW-1:0] vec_y;
        logic [TW-1:0]        target_magnitude;
    } vms_req_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic                 was_scaled;
        logic                 zero_length;
    } vms_rsp_t;

    typedef struct packed {
        logic          operation;
        logic [CW-1:0] vec_x;
        logic [CW-1:0] vec_y;
        logic [TW-1:0] target;
        logic          nx;
        logic          ny;
    } vms_side_t;

    typedef struct packed {
        logic [SW-1:0] rem;
        logic [LW-1:0] root;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        vms_side_t     side;
    } vms_sqrt_t;

    typedef struct packed {
        logic [PW-1:0] remx;
        logic [PW-1:0] remy;
        logic [TW-1:0] qx;
        logic [TW-1:0] qy;
        logic [LW-1:0] len;
        vms_side_t     side;
    } vms_div_t;

endpackage

// ===== rtl/vms_sqrt_cell.sv =====
// one root bit of the square root chain
// depends on vms_pkg
module vms_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [vms_pkg::POS_W-1:0]  pos,
    input  logic                       in_valid,
    input  vms_pkg::vms_sqrt_t         in_data,
    output logic                       out_valid,
    output vms_pkg::vms_sqrt_t         out_data
);
    import vms_pkg::*;

    logic [SW-1:0] trial;
    vms_sqrt_t     data_next;
    vms_sqrt_t     data_reg;
    logic          valid_reg;

    always_comb
    begin
        trial = (SW'(in_data.root) << ({1'b0, pos} + (POS_W+1)'(1)))
              | (SW'(1) << {pos, 1'b0});
        data_next = in_data;
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = in_data.root | (LW'(1) << pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/vms_div_cell.sv =====
// one quotient bit of both component dividers
// depends on vms_pkg
module vms_div_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [vms_pkg::POS_W-1:0]  pos,
    input  logic                       in_valid,
    input  vms_pkg::vms_div_t          in_data,
    output logic                       out_valid,
    output vms_pkg::vms_div_t          out_data
);
    import vms_pkg::*;

    logic [PW-1:0] dsh;
    vms_div_t      data_next;
    vms_div_t      data_reg;
    logic          valid_reg;

    always_comb
    begin
        dsh = PW'(in_data.len) << pos;
        data_next = in_data;
        if (in_data.remx >= dsh)
        begin
            data_next.remx = in_data.remx - dsh;
            data_next.qx   = in_data.qx | (TW'(1) << pos);
        end
        if (in_data.remy >= dsh)
        begin
            data_next.remy = in_data.remy - dsh;
            data_next.qy   = in_data.qy | (TW'(1) << pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/vector_magnitude_scaler_unit.sv =====
// top level: magnitude, square/product stage, root cell chain, divider cell chain
// depends on vms_pkg, vms_sqrt_cell, vms_div_cell
//
//   channel | signals                  | direction
//   request | req_valid, req_stall, req | in
//   result  | rsp_valid, rsp_stall, rsp | out
//
// one request per cycle while no result waits under rsp_stall; stages: magnitude, products, 24 root cells,
// 23 divider cells, output register
// the root cell chain (one root bit per cell) and divider chain set the latency
// reset clears all valid bits; payload registers are not reset
// the whole pipeline holds while a result waits under rsp_stall
module vector_magnitude_scaler_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  vms_pkg::vms_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output vms_pkg::vms_rsp_t rsp
);
    import vms_pkg::*;

    logic          en;
    logic          s0_valid_reg;
    logic [CW-1:0] s0_mx_reg;
    logic [CW-1:0] s0_my_reg;
    vms_side_t     s0_side_reg;
    vms_side_t     s0_side_next;
    logic          s1_valid_reg;
    logic [SW-1:0] s1_sqx_reg;
    logic [SW-1:0] s1_sqy_reg;
    logic [PW-1:0] s1_px_reg;
    logic [PW-1:0] s1_py_reg;
    vms_side_t     s1_side_reg;
    logic          sq_valid [0:LW];
    vms_sqrt_t     sq_data  [0:LW];
    logic          dv_valid [0:TW];
    vms_div_t      dv_data  [0:TW];
    vms_div_t      last;
    logic          scale;
    logic          zero;
    vms_rsp_t      rsp_next;
    vms_rsp_t      rsp_reg;
    logic          rsp_valid_reg;

    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !en;

    always_comb
    begin
        s0_side_next.operation = req.operation;
        s0_side_next.vec_x     = req.vec_x;
        s0_side_next.vec_y     = req.vec_y;
        s0_side_next.target    = req.target_magnitude;
        s0_side_next.nx        = req.vec_x[CW-1];
        s0_side_next.ny        = req.vec_y[CW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= req_valid;
            s1_valid_reg  <= s0_valid_reg;
            rsp_valid_reg <= dv_valid[TW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side_reg <= s0_side_next;
            s0_mx_reg   <= req.vec_x[CW-1] ? (~req.vec_x + CW'(1)) : req.vec_x;
            s0_my_reg   <= req.vec_y[CW-1] ? (~req.vec_y + CW'(1)) : req.vec_y;
            s1_sqx_reg  <= SW'(s0_mx_reg) * SW'(s0_mx_reg);
            s1_sqy_reg  <= SW'(s0_my_reg) * SW'(s0_my_reg);
            s1_px_reg   <= PW'(s0_mx_reg) * PW'(s0_side_reg.target);
            s1_py_reg   <= PW'(s0_my_reg) * PW'(s0_side_reg.target);
            s1_side_reg <= s0_side_reg;
            rsp_reg     <= rsp_next;
        end
    end

    always_comb
    begin
        sq_valid[0]     = s1_valid_reg;
        sq_data[0].rem  = s1_sqx_reg + s1_sqy_reg;
        sq_data[0].root = '0;
        sq_data[0].px   = s1_px_reg;
        sq_data[0].py   = s1_py_reg;
        sq_data[0].side = s1_side_reg;
    end

    for (genvar k = 0; k < LW; k++)
    begin : g_sqrt
        vms_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .pos       (POS_W'(LW - 1 - k)),
            .in_valid  (sq_valid[k]),
            .in_data   (sq_data[k]),
            .out_valid (sq_valid[k+1]),
            .out_data  (sq_data[k+1])
        );
    end

    always_comb
    begin
        dv_valid[0]     = sq_valid[LW];
        dv_data[0].remx = sq_data[LW].px;
        dv_data[0].remy = sq_data[LW].py;
        dv_data[0].qx   = '0;
        dv_data[0].qy   = '0;
        dv_data[0].len  = sq_data[LW].root;
        dv_data[0].side = sq_data[LW].side;
    end

    for (genvar k = 0; k < TW; k++)
    begin : g_div
        vms_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .pos       (POS_W'(TW - 1 - k)),
            .in_valid  (dv_valid[k]),
            .in_data   (dv_data[k]),
            .out_valid (dv_valid[k+1]),
            .out_data  (dv_data[k+1])
        );
    end

    always_comb
    begin
        last = dv_data[TW];
        case (vms_op_t'(last.side.operation))
            OP_LIMIT:
            begin
                scale = last.len > LW'(last.side.target);
                zero  = 1'b0;
            end
            default:
            begin
                scale = last.len != '0;
                zero  = last.len == '0;
            end
        endcase
        rsp_next.was_scaled  = scale;
        rsp_next.zero_length = zero;
        if (scale)
        begin
            rsp_next.out_x = last.side.nx ? -CW'(last.qx) : CW'(last.qx);
            rsp_next.out_y = last.side.ny ? -CW'(last.qy) : CW'(last.qy);
        end
        else if (zero)
        begin
            rsp_next.out_x = '0;
            rsp_next.out_y = '0;
        end
        else
        begin
            rsp_next.out_x = last.side.vec_x;
            rsp_next.out_y = last.side.vec_y;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.was_scaled && rsp.zero_length))
        else $error("scaled and zero length together");
    a_zero_output: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.zero_length |-> rsp.out_x == '0 && rsp.out_y == '0)
        else $error("zero length with nonzero output");
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && s0_valid_reg |=> s1_valid_reg)
        else $error("request lost between stages");
`endif

endmodule
